// ----- sv/ellipse_point_generator_macros.svh -----
// Assertion helpers for the ellipse point generator.
`ifndef ELLIPSE_POINT_GENERATOR_MACROS_SVH
`define ELLIPSE_POINT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define EPG_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("epg assertion failed");
// Next-cycle implication.
`define EPG_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("epg assertion failed");
`else
`define EPG_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons)
`define EPG_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

// ----- sv/epg_pkg.sv -----
`default_nettype none

package epg_pkg;

	// Pipeline depth: 6 stages of quarter-wave sine, 2 of scale and offset.
	localparam int NUM_STAGES = 8;

	// Taylor coefficients of sin over a quarter turn, Q30.
	localparam logic [30:0] COEF_C1 = 31'd1686629713;
	localparam logic [30:0] COEF_C3 = 31'd693598668;
	localparam logic [30:0] COEF_C5 = 31'd85569306;
	localparam logic [30:0] COEF_C7 = 31'd5026995;
	localparam logic [30:0] COEF_C9 = 31'd172272;

	localparam logic [14:0] QUARTER_TURN = 15'd16384;

	typedef logic [14:0] ang_t;      // 0..16384 over a quarter turn
	typedef logic [28:0] ang_sq_t;   // ang squared
	typedef logic [30:0] poly_t;     // Horner partial, Q30
	typedef logic [30:0] trig_mag_t; // |sin|, Q30, may pass 2^30 slightly

	typedef struct packed {
		logic        [15:0] phase;
		logic signed [15:0] centre_x;
		logic signed [15:0] centre_y;
		logic signed [15:0] half_width;
		logic signed [15:0] half_height;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] x_out;
		logic signed [15:0] y_out;
	} point_t;

	// Per-stage load enables.
	typedef struct packed {
		logic [NUM_STAGES:1] load;
	} stage_ctl_t;

endpackage

`default_nettype wire

// ----- sv/epg_sample_if.sv -----
`default_nettype none

interface epg_sample_if;
	logic             valid;
	logic             ready;
	epg_pkg::sample_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/epg_point_if.sv -----
`default_nettype none

interface epg_point_if;
	logic            valid;
	logic            ready;
	epg_pkg::point_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/epg_qsine.sv -----
`default_nettype none

module epg_qsine (
	input  wire logic               clk,
	input  wire epg_pkg::stage_ctl_t ctl,
	input  wire epg_pkg::ang_t       ang,
	output epg_pkg::trig_mag_t       mag
);
	import epg_pkg::*;

	// c - (u2 * p) >> 28; equals the Q30 form with z2 = 4*u^2.
	function automatic poly_t horner_step(ang_sq_t u2, poly_t p, poly_t c);
		logic [59:0] prod;
		logic [31:0] diff;
		prod = 60'(u2) * 60'(p);
		diff = {1'b0, c} - prod[59:28];
		return diff[30:0];
	endfunction

	logic [29:0] sq;
	logic [45:0] fin;

	ang_t      ang_s1, ang_s2, ang_s3, ang_s4, ang_s5;
	ang_sq_t   sq_s1, sq_s2, sq_s3, sq_s4;
	poly_t     p_s2, p_s3, p_s4, p_s5;
	trig_mag_t mag_s6;

	always_comb begin
		sq  = 30'(ang) * 30'(ang);
		fin = 46'(ang_s5) * 46'(p_s5);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			ang_s1 <= ang;
			sq_s1  <= sq[28:0];
		end
		if (ctl.load[2]) begin
			ang_s2 <= ang_s1;
			sq_s2  <= sq_s1;
			p_s2   <= horner_step(sq_s1, COEF_C9, COEF_C7);
		end
		if (ctl.load[3]) begin
			ang_s3 <= ang_s2;
			sq_s3  <= sq_s2;
			p_s3   <= horner_step(sq_s2, p_s2, COEF_C5);
		end
		if (ctl.load[4]) begin
			ang_s4 <= ang_s3;
			sq_s4  <= sq_s3;
			p_s4   <= horner_step(sq_s3, p_s3, COEF_C3);
		end
		if (ctl.load[5]) begin
			ang_s5 <= ang_s4;
			p_s5   <= horner_step(sq_s4, p_s4, COEF_C1);
		end
		if (ctl.load[6]) begin
			// (z * p) >> 30 with z = u << 16
			mag_s6 <= fin[44:14];
		end
	end

	assign mag = mag_s6;

endmodule

`default_nettype wire

// ----- sv/epg_scale.sv -----
`default_nettype none

module epg_scale (
	input  wire logic                clk,
	input  wire epg_pkg::stage_ctl_t  ctl,
	input  wire logic signed [16:0]   scale,
	input  wire epg_pkg::trig_mag_t   mag,
	input  wire logic signed [15:0]   centre,
	output logic signed [15:0]        res
);
	import epg_pkg::*;

	localparam logic signed [50:0] HALF_LSB = 51'sd536870912;

	logic signed [48:0] prod;
	logic signed [50:0] acc;
	logic signed [20:0] rnd;
	logic signed [15:0] sat;

	logic signed [48:0] prod_s7;
	logic signed [15:0] centre_s7;
	logic signed [15:0] res_s8;

	always_comb begin
		prod = 49'(scale) * 49'(signed'({1'b0, mag}));
		acc  = 51'(prod_s7) + (51'(centre_s7) <<< 30) + HALF_LSB;
		rnd  = acc[50:30]; // floor, so a half rounds up
		if (rnd > 21'sd32767) begin
			sat = 16'sh7fff;
		end else if (rnd < -21'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = rnd[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			prod_s7   <= prod;
			centre_s7 <= centre;
		end
		if (ctl.load[8]) begin
			res_s8 <= sat;
		end
	end

	assign res = res_s8;

endmodule

`default_nettype wire

// ----- sv/ellipse_point_generator.sv -----
// Ellipse point generator: each item on sample (phase in turns, centre, half-axes) gives one
// item on point, x = half_width*cos + centre_x and y = half_height*sin + centre_y, rounded
// and saturated to Q1.15. One item enters per clock cycle unless stalled. The eight-stage
// pipeline has a multiplier in every stage but the last: square, four Horner steps of the
// sine polynomial, final product, axis scaling, offset, rounding and saturation. A stall
// on point fills empty stages first and backs up to sample.ready only when all are full.
`default_nettype none
`include "ellipse_point_generator_macros.svh"

module ellipse_point_generator (
	input  wire logic    clk,
	input  wire logic    arst_n,
	epg_sample_if.sink   sample,
	epg_point_if.source  point
);
	import epg_pkg::*;

	typedef struct packed {
		logic        [1:0]  quad;
		logic signed [15:0] centre_x;
		logic signed [15:0] centre_y;
		logic signed [15:0] half_width;
		logic signed [15:0] half_height;
	} meta_t;

	stage_ctl_t          ctl;
	logic [NUM_STAGES:1] vld_q;

	meta_t     meta_in;
	meta_t     meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	ang_t      ang_r, ang_s;
	trig_mag_t mag_r, mag_s;
	trig_mag_t cos_mag, sin_mag;
	logic signed [16:0] scale_x, scale_y;
	logic signed [15:0] x_res, y_res;

	// A stage loads when empty or when the stage after it moves on.
	always_comb begin
		ctl.load[NUM_STAGES] = !vld_q[NUM_STAGES] || point.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			ctl.load[k] = !vld_q[k] || ctl.load[k + 1];
		end
	end

	assign sample.ready = ctl.load[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.load[1]) begin
				vld_q[1] <= sample.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (ctl.load[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	always_comb begin
		meta_in.quad        = sample.payload.phase[15:14];
		meta_in.centre_x    = sample.payload.centre_x;
		meta_in.centre_y    = sample.payload.centre_y;
		meta_in.half_width  = sample.payload.half_width;
		meta_in.half_height = sample.payload.half_height;
		ang_r = {1'b0, sample.payload.phase[13:0]};
		ang_s = QUARTER_TURN - ang_r;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			meta_s1 <= meta_in;
		end
		if (ctl.load[2]) begin
			meta_s2 <= meta_s1;
		end
		if (ctl.load[3]) begin
			meta_s3 <= meta_s2;
		end
		if (ctl.load[4]) begin
			meta_s4 <= meta_s3;
		end
		if (ctl.load[5]) begin
			meta_s5 <= meta_s4;
		end
		if (ctl.load[6]) begin
			meta_s6 <= meta_s5;
		end
	end

	epg_qsine u_sine_r (
		.clk (clk),
		.ctl (ctl),
		.ang (ang_r),
		.mag (mag_r)
	);

	epg_qsine u_sine_s (
		.clk (clk),
		.ctl (ctl),
		.ang (ang_s),
		.mag (mag_s)
	);

	// Quadrant folding: pick the magnitude, move the sign onto the half-axis.
	always_comb begin
		cos_mag = meta_s6.quad[0] ? mag_r : mag_s;
		sin_mag = meta_s6.quad[0] ? mag_s : mag_r;
		scale_x = {meta_s6.half_width[15], meta_s6.half_width};
		scale_y = {meta_s6.half_height[15], meta_s6.half_height};
		if (meta_s6.quad[1] ^ meta_s6.quad[0]) begin
			scale_x = -scale_x;
		end
		if (meta_s6.quad[1]) begin
			scale_y = -scale_y;
		end
	end

	epg_scale u_scale_x (
		.clk    (clk),
		.ctl    (ctl),
		.scale  (scale_x),
		.mag    (cos_mag),
		.centre (meta_s6.centre_x),
		.res    (x_res)
	);

	epg_scale u_scale_y (
		.clk    (clk),
		.ctl    (ctl),
		.scale  (scale_y),
		.mag    (sin_mag),
		.centre (meta_s6.centre_y),
		.res    (y_res)
	);

	assign point.valid         = vld_q[NUM_STAGES];
	assign point.payload.x_out = x_res;
	assign point.payload.y_out = y_res;

	`EPG_ASSERT_SAME(a_full_stall_blocks, clk, arst_n, (&vld_q) && !point.ready, !sample.ready)
	`EPG_ASSERT_NEXT(a_occupancy, clk, arst_n, arst_n, $countones(vld_q) == $past($countones(vld_q)) + ($past(sample.valid && sample.ready) ? 1 : 0) - ($past(point.valid && point.ready) ? 1 : 0))
	`EPG_ASSERT_NEXT(a_empty_no_output, clk, arst_n, !sample.valid && (vld_q == '0), !point.valid)

endmodule

`default_nettype wire
